// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ----- hdl/mcr_pkg.sv -----
// Types and constants of the midpoint circle rasterizer
package mcr_pkg;

    localparam int IN_COORD_W  = 12;
    localparam int RADIUS_W    = 11;
    localparam int IN_TDATA_W  = 40;
    localparam int DEC_W       = 16;
    localparam int DIM_W       = 12;
    localparam int STRIDE_W    = 14;
    localparam int OFFSET_W    = 26;
    localparam int COLOR_W     = 24;
    localparam int MIRROR_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic signed [DEC_W-1:0] DEC_INIT = 16'sd3;
    localparam logic signed [DEC_W-1:0] DEC_DIAG = 16'sd10;
    localparam logic signed [DEC_W-1:0] DEC_AXIS = 16'sd6;

    localparam logic [MIRROR_W-1:0] MIRROR_LAST = 3'd7;

    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 12'd480;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd1920;
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = 24'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COLOR  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [STRIDE_W-1:0] stride;
        logic [COLOR_W-1:0]  color;
    } t_cfg;

endpackage

// ----- hdl/mcr_front.sv -----
// Front end: accept items, run the midpoint step, queue step records
module mcr_front #(
    parameter int COORD_BITS = 12,
    localparam int REC_W = 4 * COORD_BITS + 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_kind,
    input  logic signed [mcr_pkg::IN_COORD_W-1:0]  i_center_x,
    input  logic signed [mcr_pkg::IN_COORD_W-1:0]  i_center_y,
    input  logic        [mcr_pkg::RADIUS_W-1:0]    i_radius,
    output logic                                   o_push,
    input  logic                                   i_push_ready,
    output logic        [REC_W-1:0]                o_rec
);
    import mcr_pkg::*;

    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_x, r_y;
    logic signed [COORD_BITS-1:0] n_cx, n_cy, n_x, n_y;
    logic signed [DEC_W-1:0]      r_dec, n_dec;
    logic                         r_running, n_running;

    logic                         accept, is_start, diag, done_step;
    logic signed [COORD_BITS-1:0] cx0, cy0, y0, x_step, y_step;
    logic signed [DEC_W-1:0]      dec0, xe, ye, dec_step;

    always_comb begin
        accept   = i_valid && i_push_ready;
        is_start = (i_kind == KIND_START);

        cx0  = COORD_BITS'(i_center_x);
        cy0  = COORD_BITS'(i_center_y);
        y0   = COORD_BITS'($signed({1'b0, i_radius}));
        dec0 = DEC_INIT - $signed(DEC_W'({i_radius, 1'b0}));

        diag     = (r_dec > 16'sd0);
        x_step   = r_x + COORD_BITS'(1);
        y_step   = diag ? r_y - COORD_BITS'(1) : r_y;
        xe       = DEC_W'(x_step);
        ye       = DEC_W'(y_step);
        dec_step = diag ? r_dec + ((xe - ye) <<< 2) + DEC_DIAG
                        : r_dec + (xe <<< 2) + DEC_AXIS;
        done_step = (y_step < x_step);

        o_ready = i_push_ready;
        o_push  = accept && (is_start || r_running);
        o_rec   = is_start ? {1'b0, y0, {COORD_BITS{1'b0}}, cy0, cx0}
                           : {done_step, y_step, x_step, r_cy, r_cx};
    end

    always_comb begin
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_x       = r_x;
        n_y       = r_y;
        n_dec     = r_dec;
        n_running = r_running;
        if (accept) begin
            if (is_start) begin
                n_cx      = cx0;
                n_cy      = cy0;
                n_x       = '0;
                n_y       = y0;
                n_dec     = dec0;
                n_running = 1'b1;
            end else if (r_running) begin
                n_x       = x_step;
                n_y       = y_step;
                n_dec     = dec_step;
                n_running = !done_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx      <= '0;
            r_cy      <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_dec     <= '0;
            r_running <= 1'b0;
        end else begin
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_x       <= n_x;
            r_y       <= n_y;
            r_dec     <= n_dec;
            r_running <= n_running;
        end
    end

endmodule

// ----- hdl/mcr_fifo.sv -----
// Short queue of step records between front and back end
module mcr_fifo #(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import mcr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    always_comb begin
        o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
        o_valid      = (r_count != '0);
        o_data       = r_mem[r_rd];
        push         = i_push && o_push_ready;
        pop          = i_pop && o_valid;
        n_wr         = push ? r_wr + PTR_W'(1) : r_wr;
        n_rd         = pop ? r_rd + PTR_W'(1) : r_rd;
        n_count      = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/mcr_emit.sv -----
// Back end: expand a step record into eight clipped points with offsets
module mcr_emit #(
    parameter int COORD_BITS = 12,
    localparam int REC_W = 4 * COORD_BITS + 1,
    localparam int PT_W  = COORD_BITS + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rec_valid,
    input  logic [REC_W-1:0]                    i_rec,
    output logic                                o_pop,
    input  mcr_pkg::t_cfg                       i_cfg,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [PT_W-1:0]              o_point_x,
    output logic signed [PT_W-1:0]              o_point_y,
    output logic                                o_inside,
    output logic [mcr_pkg::OFFSET_W-1:0]        o_offset,
    output logic [mcr_pkg::MIRROR_W-1:0]        o_mirror,
    output logic                                o_last,
    output logic                                o_done
);
    import mcr_pkg::*;

    localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

    logic [MIRROR_W-1:0] r_k;

    logic                 r_s1_v;
    logic signed [PT_W-1:0] r_s1_px, r_s1_py;
    logic [MIRROR_W-1:0]  r_s1_k;
    logic                 r_s1_done;

    logic                 r_s2_v;
    logic signed [PT_W-1:0] r_s2_px, r_s2_py;
    logic [MIRROR_W-1:0]  r_s2_k;
    logic                 r_s2_done, r_s2_in;
    logic [OFFSET_W-1:0]  r_s2_prod;
    logic [STRIDE_W-1:0]  r_s2_x3;

    logic                 r_o_v;
    logic signed [PT_W-1:0] r_o_px, r_o_py;
    logic [MIRROR_W-1:0]  r_o_k;
    logic                 r_o_done, r_o_in;
    logic [OFFSET_W-1:0]  r_o_off;

    logic                 s1_ready, s2_ready, s3_ready, s1_load;
    logic signed [COORD_BITS-1:0] cx, cy, sx, sy, a, b;
    logic signed [PT_W-1:0] cxe, cye, ae, be, px, py;
    logic                 rec_done, in_x, in_y;
    logic [COORD_BITS-1:0] px_u, py_u;
    logic [DIM_W-1:0]     px12, py12;

    always_comb begin
        s3_ready = !r_o_v || i_ready;
        s2_ready = !r_s2_v || s3_ready;
        s1_ready = !r_s1_v || s2_ready;
        s1_load  = i_rec_valid && s1_ready;
        o_pop    = s1_load && (r_k == MIRROR_LAST);

        cx       = i_rec[COORD_BITS-1:0];
        cy       = i_rec[2*COORD_BITS-1:COORD_BITS];
        sx       = i_rec[3*COORD_BITS-1:2*COORD_BITS];
        sy       = i_rec[4*COORD_BITS-1:3*COORD_BITS];
        rec_done = i_rec[4*COORD_BITS];

        a   = r_k[2] ? sy : sx;
        b   = r_k[2] ? sx : sy;
        cxe = PT_W'(cx);
        cye = PT_W'(cy);
        ae  = PT_W'(a);
        be  = PT_W'(b);
        px  = r_k[1] ? cxe - ae : cxe + ae;
        py  = r_k[0] ? cye - be : cye + be;

        px_u = r_s1_px[COORD_BITS-1:0];
        py_u = r_s1_py[COORD_BITS-1:0];
        px12 = DIM_W'(px_u);
        py12 = DIM_W'(py_u);
        in_x = !r_s1_px[COORD_BITS] && (CMP_W'(px_u) < CMP_W'(i_cfg.width));
        in_y = !r_s1_py[COORD_BITS] && (CMP_W'(py_u) < CMP_W'(i_cfg.height));
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_px   <= px;
            r_s1_py   <= py;
            r_s1_k    <= r_k;
            r_s1_done <= rec_done;
        end
        if (s2_ready) begin
            r_s2_px   <= r_s1_px;
            r_s2_py   <= r_s1_py;
            r_s2_k    <= r_s1_k;
            r_s2_done <= r_s1_done;
            r_s2_in   <= in_x && in_y;
            r_s2_prod <= OFFSET_W'(i_cfg.stride) * OFFSET_W'(py12);
            r_s2_x3   <= STRIDE_W'({px12, 1'b0}) + STRIDE_W'(px12);
        end
        if (s3_ready) begin
            r_o_px   <= r_s2_px;
            r_o_py   <= r_s2_py;
            r_o_k    <= r_s2_k;
            r_o_done <= r_s2_done;
            r_o_in   <= r_s2_in;
            r_o_off  <= r_s2_in ? r_s2_prod + OFFSET_W'(r_s2_x3) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s1_load) begin
                r_k <= r_k + MIRROR_W'(1);
            end
            if (s1_ready) begin
                r_s1_v <= i_rec_valid;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_ready) begin
                r_o_v <= r_s2_v;
            end
        end
    end

    assign o_valid   = r_o_v;
    assign o_point_x = r_o_px;
    assign o_point_y = r_o_py;
    assign o_inside  = r_o_in;
    assign o_offset  = r_o_off;
    assign o_mirror  = r_o_k;
    assign o_last    = (r_o_k == MIRROR_LAST);
    assign o_done    = r_o_done;

endmodule

// ----- hdl/midpoint_circle_rasterizer.sv -----
// Top level of the midpoint circle rasterizer
//
// Input stream: one transaction per item. tuser is the kind (start a circle
// or advance one step); tdata carries center and radius, read on start only.
// An advance while no circle runs is taken and dropped.
// Output stream: eight transactions per start or advance, one per mirrored
// point in fixed order; tlast marks the eighth, tuser flags the step that
// closes the circle. Points carry the clip flag, blue-byte offset and color.
// Config channel: writes image width, image height and brush color by index;
// always ready, to be written only while no point is pending.
// An item's step record is written into the step queue, and its first point then
// passes the three pipe registers before it is presented. The point expander feeds
// one point per cycle, while the receiver does not stall, into its three-stage pipe;
// a four-entry step queue lets the input run ahead meanwhile.
// Reset: synchronous, active low; clears the running circle, the queue and
// the pipe, and restores width 640, height 480 and black.
// A stalled receiver holds the output transaction; the pipe, then the queue,
// then the input channel back up behind it without loss.
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = 12,
    localparam int PT_W = COORD_BITS + 1,
    localparam int OUT_FIELDS_W = 2 * PT_W + 1 + mcr_pkg::OFFSET_W
                                  + mcr_pkg::COLOR_W + mcr_pkg::MIRROR_W,
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // center_x[11:0], center_y[23:12], radius[34:24], zero pad
    input  logic [mcr_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // kind
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // point_x, point_y, inside_res, byte_offset, pixel_color, mirror_index,
    // zero pad
    output logic [OUT_TDATA_W-1:0]              o_m_axis_tdata,
    // done_res
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mcr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mcr_pkg::COLOR_W-1:0]         i_cfg_data
);
    import mcr_pkg::*;

    localparam int REC_W = 4 * COORD_BITS + 1;

    t_cfg r_cfg, n_cfg;

    logic                  push, push_ready, rec_valid, pop;
    logic [REC_W-1:0]      rec_in, rec_out;
    logic signed [PT_W-1:0] point_x, point_y;
    logic                  in_image;
    logic [OFFSET_W-1:0]   offset;
    logic [MIRROR_W-1:0]   mirror;
    logic [DIM_W-1:0]      cfg_w;

    assign o_cfg_ready = 1'b1;
    assign cfg_w       = i_cfg_data[DIM_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH: begin
                    n_cfg.width  = cfg_w;
                    n_cfg.stride = (STRIDE_W'({cfg_w, 1'b0}) + STRIDE_W'(cfg_w)
                                    + STRIDE_W'(3)) & ~STRIDE_W'(3);
                end
                CFG_HEIGHT: n_cfg.height = i_cfg_data[DIM_W-1:0];
                CFG_COLOR:  n_cfg.color  = i_cfg_data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RESET;
            r_cfg.height <= HEIGHT_RESET;
            r_cfg.stride <= STRIDE_RESET;
            r_cfg.color  <= COLOR_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (i_s_axis_tuser),
        .i_center_x   (i_s_axis_tdata[IN_COORD_W-1:0]),
        .i_center_y   (i_s_axis_tdata[2*IN_COORD_W-1:IN_COORD_W]),
        .i_radius     (i_s_axis_tdata[2*IN_COORD_W+RADIUS_W-1:2*IN_COORD_W]),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_rec        (rec_in)
    );

    mcr_fifo #(.WIDTH(REC_W)) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_data       (rec_in),
        .o_valid      (rec_valid),
        .i_pop        (pop),
        .o_data       (rec_out)
    );

    mcr_emit #(.COORD_BITS(COORD_BITS)) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec_out),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_point_x   (point_x),
        .o_point_y   (point_y),
        .o_inside    (in_image),
        .o_offset    (offset),
        .o_mirror    (mirror),
        .o_last      (o_m_axis_tlast),
        .o_done      (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({mirror, r_cfg.color, offset, in_image,
                                          point_y, point_x});

endmodule

// ----- hdl/mcr_checker.sv -----
// Port-level checker for the midpoint circle rasterizer, with its bind
`include "assert_macros.svh"

module mcr_checker #(
    parameter int COORD_BITS = 12,
    localparam int PT_W = COORD_BITS + 1,
    localparam int OUT_FIELDS_W = 2 * PT_W + 1 + mcr_pkg::OFFSET_W
                                  + mcr_pkg::COLOR_W + mcr_pkg::MIRROR_W,
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic                   o_m_axis_tlast,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import mcr_pkg::*;

    localparam int IN_BIT   = 2 * PT_W;
    localparam int OFF_LSB  = IN_BIT + 1;
    localparam int MIR_LSB  = OFF_LSB + OFFSET_W + COLOR_W;

    logic [MIRROR_W-1:0] r_exp_mirror;
    logic [MIRROR_W-1:0] mirror;
    logic [OFFSET_W-1:0] offset;
    logic                in_image;
    logic                stalled;

    assign mirror   = o_m_axis_tdata[MIR_LSB +: MIRROR_W];
    assign offset   = o_m_axis_tdata[OFF_LSB +: OFFSET_W];
    assign in_image = o_m_axis_tdata[IN_BIT];
    assign stalled  = o_m_axis_tvalid && !i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_mirror <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_exp_mirror <= r_exp_mirror + MIRROR_W'(1);
        end
    end

    `ASSERT_NEXT(a_hold_stalled, stalled, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `ASSERT_IMPL(a_mirror_order, o_m_axis_tvalid, mirror == r_exp_mirror)
    `ASSERT_IMPL(a_last_on_eighth, o_m_axis_tvalid, o_m_axis_tlast == (mirror == MIRROR_LAST))
    `ASSERT_IMPL(a_clipped_offset, o_m_axis_tvalid && !in_image, offset == '0)

endmodule

bind midpoint_circle_rasterizer mcr_checker #(.COORD_BITS(COORD_BITS)) u_mcr_checker (.*);
